@@ hdl/mpbf_pkg.sv @@
// Shared types, constants and codes of the mask/pattern filter bank.
`timescale 1ns / 1ps

package mpbf_pkg;

  localparam int NUM_FILTERS      = 8;
  localparam int MAX_FILTER_BYTES = 16;
  localparam int IDX_W            = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
  localparam int ENTRY_W          = 16;  // mask byte over pattern byte

  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_MSG   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_KIND    = 2'd1,
    ST_NOT_ACTIVE  = 2'd2,
    ST_TOO_LONG    = 2'd3
  } status_e;

  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_BLOCK = 2'd1;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] filter_slot;
    logic [3:0] byte_index;
    logic [7:0] mask_byte;
    logic [7:0] pattern_byte;
    logic [1:0] filter_kind;
    logic [4:0] mask_length;
    logic [4:0] pattern_length;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       accepted;
    logic       is_message_result;
  } result_t;

  // Decoded operation from the item stage to the slot bank
  typedef struct packed {
    logic       load_en;
    logic       start_en;
    logic       stop_en;
    logic       clear_en;
    logic       msg_en;
    logic       last;
    logic [2:0] slot;
    logic [3:0] idx;
    logic [7:0] mask;
    logic [7:0] pattern;
    logic       is_block;
    logic [4:0] len;
    logic [7:0] data;
  } bank_ctrl_t;

  // Slot bank answers back to the item stage
  typedef struct packed {
    logic sel_active;
    logic has_pass;
    logic pass_hit;
    logic block_hit;
  } bank_stat_t;

endpackage

@@ hdl/mpbf_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module mpbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mpbf_slot_bank.sv @@
// Filter slots: per-slot mask/pattern memories, slot state and byte compare.
`timescale 1ns / 1ps

module mpbf_slot_bank (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpbf_pkg::bank_ctrl_t ctrl_i,
  input  logic [4:0]         count_q_i,    // position of the byte being handled
  input  logic [4:0]         count_inc_i,  // saturated count after this byte
  input  logic [4:0]         count_d_i,    // position of the next byte
  output mpbf_pkg::bank_stat_t stat_o
);

  import mpbf_pkg::*;

  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic [NUM_FILTERS-1:0] active_q, active_d;
  logic [NUM_FILTERS-1:0] block_q, block_d;
  logic [4:0]             len_q [NUM_FILTERS];
  logic [4:0]             len_d [NUM_FILTERS];
  logic [NUM_FILTERS-1:0] mism_q, mism_d, mism_new;
  logic [NUM_FILTERS-1:0] hit;
  logic [NUM_FILTERS-1:0] sel;

  assign rd_addr = IDX_W'(count_d_i);
  assign wr_addr = IDX_W'(ctrl_i.idx);

  for (genvar i = 0; i < NUM_FILTERS; i++) begin : g_slot
    logic [MAX_FILTER_BYTES-1:0] valid_q;
    logic                        valid_rd_q;
    logic                        fwd_q;
    logic [ENTRY_W-1:0]          fwd_data_q;
    logic [ENTRY_W-1:0]          ram_rdata;
    logic [ENTRY_W-1:0]          entry;
    logic                        we;
    logic                        neq;
    logic                        mism_bit;
    logic                        hit_bit;

    assign sel[i] = (32'(ctrl_i.slot) == i);
    assign we     = ctrl_i.load_en & sel[i];

    mpbf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_FILTER_BYTES)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (wr_addr),
      .wdata_i ({ctrl_i.mask, ctrl_i.pattern}),
      .raddr_i (rd_addr),
      .rdata_o (ram_rdata)
    );

    // Entries never written read as zero
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q    <= '0;
        valid_rd_q <= 1'b0;
        fwd_q      <= 1'b0;
      end else begin
        if (we) begin
          valid_q[wr_addr] <= 1'b1;
        end
        valid_rd_q <= valid_q[rd_addr];
        fwd_q      <= we && (wr_addr == rd_addr);
      end
    end

    // Forward a load that lands on the entry being prefetched
    always_ff @(posedge clk_i) begin
      fwd_data_q <= {ctrl_i.mask, ctrl_i.pattern};
    end

    always_comb begin
      if (fwd_q) begin
        entry = fwd_data_q;
      end else if (valid_rd_q) begin
        entry = ram_rdata;
      end else begin
        entry = '0;
      end
      neq = ((ctrl_i.data & entry[15:8]) != (entry[7:0] & entry[15:8]));
      mism_bit = mism_q[i] |
                 (ctrl_i.msg_en & active_q[i] & (count_q_i < len_q[i]) & neq);
      hit_bit = (len_q[i] == 5'd0) || (!mism_bit && (count_inc_i >= len_q[i]));
    end

    assign mism_new[i] = mism_bit;
    assign hit[i]      = hit_bit;
  end

  always_comb begin
    active_d = active_q;
    block_d  = block_q;
    len_d    = len_q;
    mism_d   = mism_new;
    for (int i = 0; i < NUM_FILTERS; i++) begin
      if (ctrl_i.clear_en) begin
        active_d[i] = 1'b0;
      end
      if (ctrl_i.stop_en && sel[i]) begin
        active_d[i] = 1'b0;
      end
      if (ctrl_i.start_en && sel[i]) begin
        active_d[i] = 1'b1;
        block_d[i]  = ctrl_i.is_block;
        len_d[i]    = ctrl_i.len;
        mism_d[i]   = 1'b0;
      end
      if (ctrl_i.msg_en && ctrl_i.last) begin
        mism_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      block_q  <= '0;
      mism_q   <= '0;
      for (int i = 0; i < NUM_FILTERS; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      active_q <= active_d;
      block_q  <= block_d;
      mism_q   <= mism_d;
      len_q    <= len_d;
    end
  end

  always_comb begin
    stat_o = '0;
    for (int i = 0; i < NUM_FILTERS; i++) begin
      if (sel[i] && active_q[i]) begin
        stat_o.sel_active = 1'b1;
      end
      if (active_q[i] && block_q[i] && hit[i]) begin
        stat_o.block_hit = 1'b1;
      end
      if (active_q[i] && !block_q[i]) begin
        stat_o.has_pass = 1'b1;
        if (hit[i]) begin
          stat_o.pass_hit = 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/mask_pattern_pass_block_filter_core.sv @@
// Top level of the mask/pattern pass/block receive filter bank.
`timescale 1ns / 1ps

// Receive acceptance filter bank. Drive one item per cycle with start; busy
// is never raised, so an item is taken at every edge where start is high.
// Each item passes an input register and then a result register: a command
// acknowledgement, or the verdict of a message at its last byte, appears on
// result_o from the result register, with result_valid_o high for exactly
// one cycle. Message bytes other than the last give no result, and
// undefined command codes are dropped silently. The receiver cannot stall,
// so sample result_o whenever result_valid_o is high. Throughput is one item
// per cycle; the mask and pattern memory of every slot is read ahead at the
// next byte position, which keeps the per-byte compare between the two
// registers. After reset all stored bytes read as zero through per-entry
// valid bits; no clearing pass is needed.
module mask_pattern_pass_block_filter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mpbf_pkg::in_item_t in_item_i,
  output logic               result_valid_o,
  output mpbf_pkg::result_t  result_o
);

  import mpbf_pkg::*;

  logic       item_valid_q;
  in_item_t   item_q;
  logic [4:0] count_q, count_d, count_inc;
  logic       res_valid_q, res_valid_d;
  result_t    res_q, res_d;
  logic [4:0] start_len;
  logic       slot_ok;
  logic       idx_ok;
  logic       kind_ok;
  logic       len_ok;
  bank_ctrl_t ctrl;
  bank_stat_t stat;

  // Never stall the sender
  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      item_q <= in_item_i;
    end
  end

  // Decode the held item
  assign start_len = (item_q.mask_length < item_q.pattern_length) ?
                     item_q.mask_length : item_q.pattern_length;
  assign slot_ok   = (32'(item_q.filter_slot) < NUM_FILTERS);
  assign idx_ok    = (32'(item_q.byte_index) < MAX_FILTER_BYTES);
  assign kind_ok   = (item_q.filter_kind == KIND_PASS) || (item_q.filter_kind == KIND_BLOCK);
  assign len_ok    = (32'(start_len) <= MAX_FILTER_BYTES);

  always_comb begin
    ctrl          = '0;
    ctrl.last     = item_q.last_byte;
    ctrl.slot     = item_q.filter_slot;
    ctrl.idx      = item_q.byte_index;
    ctrl.mask     = item_q.mask_byte;
    ctrl.pattern  = item_q.pattern_byte;
    ctrl.is_block = (item_q.filter_kind == KIND_BLOCK);
    ctrl.len      = start_len;
    ctrl.data     = item_q.data_byte;
    if (item_valid_q) begin
      case (item_q.command)
        CMD_LOAD:  ctrl.load_en  = slot_ok & idx_ok;
        CMD_START: ctrl.start_en = slot_ok & kind_ok & len_ok;
        CMD_STOP:  ctrl.stop_en  = slot_ok;
        CMD_CLEAR: ctrl.clear_en = 1'b1;
        CMD_MSG:   ctrl.msg_en   = 1'b1;
        default:   ctrl          = ctrl;
      endcase
    end
  end

  // Byte position within the message; saturate so long messages stay above
  // every filter length
  assign count_inc = (count_q == COUNT_MAX) ? count_q : (count_q + 5'd1);

  always_comb begin
    count_d = count_q;
    if (ctrl.msg_en) begin
      count_d = ctrl.last ? 5'd0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  mpbf_slot_bank u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .count_q_i   (count_q),
    .count_inc_i (count_inc),
    .count_d_i   (count_d),
    .stat_o      (stat)
  );

  // Build the result for the held item
  always_comb begin
    res_valid_d = 1'b0;
    res_d       = '0;
    if (item_valid_q) begin
      case (item_q.command)
        CMD_MSG: begin
          res_valid_d             = item_q.last_byte;
          res_d.is_message_result = 1'b1;
          res_d.accepted          = !stat.block_hit && (!stat.has_pass || stat.pass_hit);
        end
        CMD_CLEAR: begin
          res_valid_d = 1'b1;
        end
        CMD_LOAD: begin
          res_valid_d = 1'b1;
          if (!slot_ok) begin
            res_d.status = ST_NOT_ACTIVE;
          end else if (!idx_ok) begin
            res_d.status = ST_TOO_LONG;
          end
        end
        CMD_START: begin
          res_valid_d = 1'b1;
          if (!slot_ok) begin
            res_d.status = ST_NOT_ACTIVE;
          end else if (!kind_ok) begin
            res_d.status = ST_BAD_KIND;
          end else if (!len_ok) begin
            res_d.status = ST_TOO_LONG;
          end
        end
        CMD_STOP: begin
          res_valid_d = 1'b1;
          if (!slot_ok || !stat.sel_active) begin
            res_d.status = ST_NOT_ACTIVE;
          end
        end
        default: begin
          res_valid_d = 1'b0;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A result only follows an item held in the input register
  a_res_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(item_valid_q))
    else $error("result without a held item");

  // Message verdicts always carry status ok
  a_msg_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.is_message_result) |-> (res_q.status == ST_OK))
    else $error("message result with nonzero status");

  // Command acknowledgements never report acceptance
  a_ack_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.is_message_result) |-> !res_q.accepted)
    else $error("command acknowledgement marked accepted");

  // The byte position restarts after the last byte of a message
  a_count_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.msg_en && ctrl.last) |=> (count_q == 5'd0))
    else $error("byte position not cleared after last byte");

endmodule

@@ test/filter_verdict_checker.sv @@
// Checker of the filter bank: predicts acknowledgements and verdicts and compares them.
`timescale 1ns / 1ps

module filter_verdict_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  mpbf_pkg::in_item_t item_i,
  input  logic               result_valid_i,
  input  mpbf_pkg::result_t  result_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import mpbf_pkg::*;

  logic [7:0] mask_mem [NUM_FILTERS][MAX_FILTER_BYTES];
  logic [7:0] pat_mem  [NUM_FILTERS][MAX_FILTER_BYTES];
  bit         slot_on  [NUM_FILTERS];
  bit         slot_blk [NUM_FILTERS];
  bit         slot_miss[NUM_FILTERS];
  logic [4:0] slot_len [NUM_FILTERS];
  logic [4:0] byte_pos;

  result_t verdict_q[$];
  int      errors = 0;

  assign fail_count_o = errors;

  task automatic report_error(input string what);
    errors++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Apply one item to the predicted bank and queue the result it causes.
  task automatic model_item(input in_item_t it);
    result_t r;
    bit      emit;
    bit      has_pass, pass_hit, block_hit, hit;
    int      slot, idx, len, pos, cnt;
    r         = '0;
    emit      = 1'b1;
    has_pass  = 1'b0;
    pass_hit  = 1'b0;
    block_hit = 1'b0;
    slot      = int'(it.filter_slot);
    idx       = int'(it.byte_index);
    len       = (it.mask_length < it.pattern_length) ? int'(it.mask_length) :
                                                       int'(it.pattern_length);
    case (it.command)
      CMD_MSG: begin
        pos = int'(byte_pos);
        for (int i = 0; i < NUM_FILTERS; i++) begin
          if (slot_on[i] && pos < int'(slot_len[i])) begin
            if ((it.data_byte & mask_mem[i][pos]) != (pat_mem[i][pos] & mask_mem[i][pos]))
              slot_miss[i] = 1'b1;
          end
        end
        cnt      = (pos + 1 > int'(COUNT_MAX)) ? int'(COUNT_MAX) : pos + 1;
        byte_pos = cnt[4:0];
        if (!it.last_byte) begin
          emit = 1'b0;
        end else begin
          for (int i = 0; i < NUM_FILTERS; i++) begin
            if (slot_on[i]) begin
              hit = (slot_len[i] == 5'd0) || (!slot_miss[i] && cnt >= int'(slot_len[i]));
              if (slot_blk[i]) begin
                if (hit) block_hit = 1'b1;
              end else begin
                has_pass = 1'b1;
                if (hit) pass_hit = 1'b1;
              end
            end
            slot_miss[i] = 1'b0;
          end
          byte_pos            = '0;
          r.is_message_result = 1'b1;
          r.accepted          = !block_hit && (!has_pass || pass_hit);
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NUM_FILTERS; i++) slot_on[i] = 1'b0;
      end
      CMD_LOAD: begin
        if (slot >= NUM_FILTERS) begin
          r.status = ST_NOT_ACTIVE;
        end else if (idx >= MAX_FILTER_BYTES) begin
          r.status = ST_TOO_LONG;
        end else begin
          mask_mem[slot][idx] = it.mask_byte;
          pat_mem[slot][idx]  = it.pattern_byte;
        end
      end
      CMD_START: begin
        if (slot >= NUM_FILTERS) begin
          r.status = ST_NOT_ACTIVE;
        end else if (it.filter_kind != KIND_PASS && it.filter_kind != KIND_BLOCK) begin
          r.status = ST_BAD_KIND;
        end else if (len > MAX_FILTER_BYTES) begin
          r.status = ST_TOO_LONG;
        end else begin
          slot_on[slot]   = 1'b1;
          slot_blk[slot]  = (it.filter_kind == KIND_BLOCK);
          slot_len[slot]  = len[4:0];
          slot_miss[slot] = 1'b0;
        end
      end
      CMD_STOP: begin
        if (slot >= NUM_FILTERS || !slot_on[slot]) r.status = ST_NOT_ACTIVE;
        else slot_on[slot] = 1'b0;
      end
      default: emit = 1'b0;
    endcase
    if (emit) verdict_q = {verdict_q, r};
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (verdict_q.size() == 0) begin
      report_error($sformatf("unexpected result status=%0d accepted=%b message=%b",
                             got.status, got.accepted, got.is_message_result));
      return;
    end
    want = verdict_q.pop_front();
    if (got.status !== want.status || got.accepted !== want.accepted ||
        got.is_message_result !== want.is_message_result)
      report_error($sformatf("result status=%0d accepted=%b message=%b, want %0d %b %b",
                             got.status, got.accepted, got.is_message_result,
                             want.status, want.accepted, want.is_message_result));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FILTERS; i++) begin
        for (int j = 0; j < MAX_FILTER_BYTES; j++) begin
          mask_mem[i][j] = '0;
          pat_mem[i][j]  = '0;
        end
        slot_on[i]   = 1'b0;
        slot_blk[i]  = 1'b0;
        slot_miss[i] = 1'b0;
        slot_len[i]  = '0;
      end
      byte_pos = '0;
      verdict_q.delete();
    end else begin
      // Compare first: a result never belongs to the item taken at the same edge.
      if (result_valid_i !== 1'b0) check_result(result_i);
      if (start_i && !busy_i) model_item(item_i);
    end
    pending_o <= verdict_q.size();
  end

endmodule

@@ test/testbench.sv @@
// Top of the filter bank testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import mpbf_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 8;       // margin after the last expected result

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start   = 1'b0;
  in_item_t in_item = '0;
  logic     busy;
  logic     result_valid;
  result_t  result;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent = 0;     // items that the block acts on; undefined codes do not count
  bit quiet = 1'b0; // suppress sender gaps

  // Stimulus-side copy of the stored bytes, used only to aim messages at a slot.
  logic [7:0] shadow_mask[NUM_FILTERS][MAX_FILTER_BYTES];
  logic [7:0] shadow_pat [NUM_FILTERS][MAX_FILTER_BYTES];

  mask_pattern_pass_block_filter_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_item_i      (in_item),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  filter_verdict_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (in_item),
    .result_valid_i (result_valid),
    .result_i       (result),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Random filler: fields that a command ignores still carry random bits.
  function automatic in_item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // Drive one item at the falling edge and hold it until the block takes it.
  // Idle each cycle with a fixed chance first, with junk on the payload.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < 26) gap++;
    end
    repeat (gap) begin
      @(negedge clk_i);
      start   <= 1'b0;
      in_item <= noise_item();
    end
    @(negedge clk_i);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (it.command <= CMD_MSG) sent++;
    if (it.command == CMD_LOAD) begin
      shadow_mask[it.filter_slot][it.byte_index] = it.mask_byte;
      shadow_pat[it.filter_slot][it.byte_index]  = it.pattern_byte;
    end
  endtask

  task automatic load_byte(input int slot, input int idx, input logic [7:0] m,
                           input logic [7:0] p);
    in_item_t it;
    it              = noise_item();
    it.command      = CMD_LOAD;
    it.filter_slot  = slot[2:0];
    it.byte_index   = idx[3:0];
    it.mask_byte    = m;
    it.pattern_byte = p;
    send_item(it);
  endtask

  task automatic start_filter(input int slot, input logic [1:0] kind,
                              input logic [4:0] mlen, input logic [4:0] plen);
    in_item_t it;
    it                = noise_item();
    it.command        = CMD_START;
    it.filter_slot    = slot[2:0];
    it.filter_kind    = kind;
    it.mask_length    = mlen;
    it.pattern_length = plen;
    send_item(it);
  endtask

  // Stop, clear, or an undefined code.
  task automatic plain_cmd(input logic [2:0] cmd, input int slot);
    in_item_t it;
    it             = noise_item();
    it.command     = cmd;
    it.filter_slot = slot[2:0];
    send_item(it);
  endtask

  task automatic msg_byte(input logic [7:0] d, input bit last);
    in_item_t it;
    it           = noise_item();
    it.command   = CMD_MSG;
    it.data_byte = d;
    it.last_byte = last;
    send_item(it);
  endtask

  task automatic random_command();
    int         sel;
    logic [7:0] m;
    logic [1:0] kind;
    logic [4:0] mlen, plen;
    sel = $urandom_range(99);
    if (sel < 40) begin
      case ($urandom_range(9))
        0:       m = 8'h00;
        1:       m = 8'hFF;
        default: m = 8'($urandom);
      endcase
      load_byte($urandom_range(NUM_FILTERS - 1), $urandom_range(MAX_FILTER_BYTES - 1),
                m, 8'($urandom));
    end else if (sel < 68) begin
      // Mostly supported kinds and lengths that fit; a few bad ones.
      kind = ($urandom_range(99) < 10) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
      mlen = ($urandom_range(99) < 85) ? 5'($urandom_range(MAX_FILTER_BYTES)) :
                                         5'($urandom_range(31));
      plen = ($urandom_range(99) < 85) ? 5'($urandom_range(MAX_FILTER_BYTES)) :
                                         5'($urandom_range(31));
      start_filter($urandom_range(NUM_FILTERS - 1), kind, mlen, plen);
    end else if (sel < 88) begin
      plain_cmd(CMD_STOP, $urandom_range(NUM_FILTERS - 1));
    end else if (sel < 94) begin
      plain_cmd(CMD_CLEAR, $urandom_range(NUM_FILTERS - 1));
    end else begin
      plain_cmd(3'($urandom_range(7, 5)), $urandom_range(NUM_FILTERS - 1));
    end
  endtask

  // Stream a message that mostly matches the given slot's stored bytes, so
  // that filters actually hit; now and then slip a command in between bytes.
  task automatic send_message(input int slot, input int n);
    logic [7:0] d;
    for (int p = 0; p < n; p++) begin
      if ($urandom_range(99) < 4) random_command();
      if (p < MAX_FILTER_BYTES && $urandom_range(99) < 85)
        d = (shadow_pat[slot][p] & shadow_mask[slot][p]) |
            (8'($urandom) & ~shadow_mask[slot][p]);
      else
        d = 8'($urandom);
      msg_byte(d, p == n - 1);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_FILTERS; i++) begin
      for (int j = 0; j < MAX_FILTER_BYTES; j++) begin
        shadow_mask[i][j] = '0;
        shadow_pat[i][j]  = '0;
      end
    end

    // Hold reset low from the start, then release it at a falling edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    msg_byte(8'h00, 1'b1);                  // no filter at all: accept
    load_byte(0, 0, 8'hFF, 8'h12);
    load_byte(0, 1, 8'h0F, 8'hA5);
    load_byte(7, MAX_FILTER_BYTES - 1, 8'hFF, 8'hFF);
    start_filter(0, KIND_PASS, 5'd2, 5'd5); // length is the smaller one
    msg_byte(8'h12, 1'b0);
    msg_byte(8'h35, 1'b1);                  // masked low nibble matches: accept
    msg_byte(8'h12, 1'b1);                  // shorter than the filter: reject
    start_filter(7, KIND_BLOCK, 5'd0, 5'd31); // zero length block matches all
    msg_byte(8'hFF, 1'b1);
    plain_cmd(CMD_STOP, 7);
    plain_cmd(CMD_STOP, 7);                 // already stopped
    start_filter(3, 2'd2, 5'd4, 5'd4);      // unsupported kinds
    start_filter(3, 2'd3, 5'd4, 5'd4);
    start_filter(3, KIND_PASS, 5'd31, 5'd17); // too long
    start_filter(2, KIND_BLOCK, 5'd16, 5'd16); // longest allowed length
    msg_byte(8'h77, 1'b0);
    load_byte(0, 1, 8'hFF, 8'h00);          // rewrite an active slot mid-message
    start_filter(0, KIND_PASS, 5'd2, 5'd2); // restart mid-message drops the miss
    msg_byte(8'h00, 1'b1);
    plain_cmd(3'd5, 1);                     // undefined codes: dropped
    plain_cmd(3'd6, 2);
    plain_cmd(3'd7, 3);
    plain_cmd(CMD_CLEAR, 0);

    // Random part, with a stretch of back-to-back items in the middle.
    while (sent < ITEM_TARGET) begin
      quiet = (sent >= 800 && sent < 1100);
      if ($urandom_range(99) < 55)
        send_message($urandom_range(NUM_FILTERS - 1),
                     ($urandom_range(99) < 10) ? $urandom_range(40, 19) : $urandom_range(18, 1));
      else
        random_command();
    end

    // Drop start, let every expected result arrive, then drain.
    @(negedge clk_i);
    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
